>>> rtl/rssc_pkg.sv
`default_nettype none

package rssc_pkg;

    localparam int ROTOR_POSITIONS = 10;
    localparam int TABLE_ENTRIES   = 10;
    localparam int ALPHABET_LEN    = 27;
    localparam int FIFO_DEPTH      = 2;

    localparam int POS_W   = 4;
    localparam int KEY_W   = 6;
    localparam int IDX_W   = 5;
    localparam int TABLE_W = 40;
    localparam int CFG_IDX_W = 3;

    localparam logic [TABLE_W-1:0] TABLE_RESET = 40'h8462591037;

    localparam logic [CFG_IDX_W-1:0] CFG_START_FAST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SLOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTOR_TABLE = 3'd4;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic [7:0] in_char;
        logic       start_message;
    } in_t;

    typedef struct packed {
        logic [7:0]       out_char;
        logic [KEY_W-1:0] key_used;
    } out_t;

    typedef struct packed {
        logic [POS_W-1:0]   start_pos_fast;
        logic [POS_W-1:0]   start_pos_mid;
        logic [POS_W-1:0]   start_pos_slow;
        logic               direction;
        logic [TABLE_W-1:0] rotor_table;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] sym_idx;
        logic [KEY_W-1:0] key;
    } q_entry_t;

    function automatic logic [3:0] table_entry(input logic [TABLE_W-1:0] tbl,
                                               input logic [POS_W-1:0] pos);
        logic [5:0] base;
        base = {pos, 2'b00};
        if ({1'b0, pos} >= 5'(TABLE_ENTRIES)) begin
            return 4'd0;
        end
        return tbl[base +: 4];
    endfunction

endpackage

`default_nettype wire

>>> rtl/rssc_fifo.sv
`default_nettype none

module rssc_fifo #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rssc_front.sv
`default_nettype none

module rssc_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rssc_pkg::cfg_t    cfg,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rssc_pkg::in_t     s_data,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output rssc_pkg::q_entry_t     push_data
);

    localparam int POS_W = rssc_pkg::POS_W;

    logic [POS_W-1:0] pos_fast_reg, pos_fast_next;
    logic [POS_W-1:0] pos_mid_reg, pos_mid_next;
    logic [POS_W-1:0] pos_slow_reg, pos_slow_next;
    logic [POS_W-1:0] cur_fast, cur_mid, cur_slow;
    logic             wrap_fast, wrap_mid, wrap_slow;
    logic [7:0]       folded;
    logic             accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    always_comb begin
        if (s_data.start_message) begin
            cur_fast = cfg.start_pos_fast;
            cur_mid  = cfg.start_pos_mid;
            cur_slow = cfg.start_pos_slow;
        end else begin
            cur_fast = pos_fast_reg;
            cur_mid  = pos_mid_reg;
            cur_slow = pos_slow_reg;
        end
    end

    always_comb begin
        folded = s_data.in_char;
        if (s_data.in_char >= rssc_pkg::CHAR_LOWER_A
                && s_data.in_char <= rssc_pkg::CHAR_LOWER_Z) begin
            folded = s_data.in_char - rssc_pkg::CASE_OFFSET;
        end
        // Space and any unknown character both land on the last symbol after the index shift.
        if (folded >= rssc_pkg::CHAR_UPPER_A && folded <= rssc_pkg::CHAR_UPPER_Z) begin
            push_data.sym_idx = rssc_pkg::IDX_W'(folded - rssc_pkg::CHAR_UPPER_A);
        end else begin
            push_data.sym_idx = rssc_pkg::IDX_W'(rssc_pkg::ALPHABET_LEN - 1);
        end
        push_data.key = rssc_pkg::KEY_W'(rssc_pkg::table_entry(cfg.rotor_table, cur_fast))
                      + rssc_pkg::KEY_W'(rssc_pkg::table_entry(cfg.rotor_table, cur_mid))
                      + rssc_pkg::KEY_W'(rssc_pkg::table_entry(cfg.rotor_table, cur_slow));
    end

    always_comb begin
        wrap_fast = ({1'b0, cur_fast} + 1'b1) >= (POS_W + 1)'(rssc_pkg::ROTOR_POSITIONS);
        wrap_mid  = ({1'b0, cur_mid}  + 1'b1) >= (POS_W + 1)'(rssc_pkg::ROTOR_POSITIONS);
        wrap_slow = ({1'b0, cur_slow} + 1'b1) >= (POS_W + 1)'(rssc_pkg::ROTOR_POSITIONS);
        pos_fast_next = wrap_fast ? '0 : cur_fast + 1'b1;
        pos_mid_next  = cur_mid;
        pos_slow_next = cur_slow;
        if (wrap_fast) begin
            pos_mid_next = wrap_mid ? '0 : cur_mid + 1'b1;
            if (wrap_mid) begin
                pos_slow_next = wrap_slow ? '0 : cur_slow + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_fast_reg <= '0;
            pos_mid_reg  <= '0;
            pos_slow_reg <= '0;
        end else if (accept) begin
            pos_fast_reg <= pos_fast_next;
            pos_mid_reg  <= pos_mid_next;
            pos_slow_reg <= pos_slow_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rssc_back.sv
`default_nettype none

module rssc_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               direction,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire rssc_pkg::q_entry_t pop_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rssc_pkg::out_t          m_data
);

    localparam logic [5:0] LEN = 6'(rssc_pkg::ALPHABET_LEN);

    logic                 m_valid_reg, m_valid_next;
    rssc_pkg::out_t       m_data_reg;
    rssc_pkg::out_t       result;
    logic [4:0]           key_mod;
    logic [5:0]           sum;
    logic [4:0]           sym;

    assign pop_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        key_mod = (pop_data.key >= LEN) ? 5'(pop_data.key - LEN) : pop_data.key[4:0];
        if (direction == rssc_pkg::DIR_DECRYPT) begin
            sum = 6'(pop_data.sym_idx) + LEN - 6'(key_mod);
        end else begin
            sum = 6'(pop_data.sym_idx) + 6'(key_mod);
        end
        sym = (sum >= LEN) ? 5'(sum - LEN) : sum[4:0];
        if (sym == 5'(rssc_pkg::ALPHABET_LEN - 1)) begin
            result.out_char = rssc_pkg::CHAR_SPACE;
        end else begin
            result.out_char = rssc_pkg::CHAR_UPPER_A + 8'(sym);
        end
        result.key_used = pop_data.key;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop_valid && pop_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            m_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rotor_stepped_shift_cipher.sv
// Rotor-stepped shift cipher over the alphabet A to Z and space. It takes one
// character beat per clock cycle at a sustained rate while the queue has room.
// The front looks up the rotor keys combinationally, steps the rotors as a
// character is accepted and writes its symbol and key into the queue; the back
// registers the modulo-27 shift of the queue head into the output. A short
// queue between the two lets a stalled output hold up the input only once the
// queue is full. Configuration is written only while the block is idle: the
// user must keep to this, as the block itself does not enforce it. A new start
// position takes effect at the next beat that carries the start flag.
`default_nettype none

module rotor_stepped_shift_cipher #(
    parameter int FIFO_DEPTH = rssc_pkg::FIFO_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire rssc_pkg::in_t                     s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output rssc_pkg::out_t                         m_data,
    input  wire logic                              cfg_wr_en,
    input  wire logic [rssc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rssc_pkg::TABLE_W-1:0]      cfg_wr_data
);

    localparam int Q_W = $bits(rssc_pkg::q_entry_t);

    rssc_pkg::cfg_t     cfg_reg;
    rssc_pkg::q_entry_t push_data, pop_data;
    logic [Q_W-1:0]     pop_bits;
    logic               push_valid, push_ready;
    logic               pop_valid, pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_pos_fast <= '0;
            cfg_reg.start_pos_mid  <= '0;
            cfg_reg.start_pos_slow <= '0;
            cfg_reg.direction      <= rssc_pkg::DIR_ENCRYPT;
            cfg_reg.rotor_table    <= rssc_pkg::TABLE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rssc_pkg::CFG_START_FAST:  cfg_reg.start_pos_fast <= cfg_wr_data[3:0];
                rssc_pkg::CFG_START_MID:   cfg_reg.start_pos_mid  <= cfg_wr_data[3:0];
                rssc_pkg::CFG_START_SLOW:  cfg_reg.start_pos_slow <= cfg_wr_data[3:0];
                rssc_pkg::CFG_DIRECTION:   cfg_reg.direction      <= cfg_wr_data[0];
                rssc_pkg::CFG_ROTOR_TABLE: cfg_reg.rotor_table    <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    rssc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rssc_fifo #(
        .WIDTH (Q_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_bits)
    );

    assign pop_data = pop_bits;

    rssc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .direction (cfg_reg.direction),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

>>> rtl/rssc_checker.sv
`default_nettype none

module rssc_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire rssc_pkg::out_t m_data
);

    // A stalled result beat holds its value.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("accepted beat produced no result in time");

    // With the output empty the queue cannot be full.
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output is empty");

endmodule

bind rotor_stepped_shift_cipher rssc_checker u_checker (.*);

`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none

module tb_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_PHASES = 12;
    localparam int BEATS_PER_PHASE = 134;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    rssc_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rssc_pkg::out_t m_data;
    logic                           cfg_wr_en = 1'b0;
    logic [rssc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rssc_pkg::TABLE_W-1:0]   cfg_wr_data = '0;

    rotor_stepped_shift_cipher dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // Shadow copy of the registers and the rotor positions.
    rssc_pkg::cfg_t shadow_cfg = '{start_pos_fast: '0, start_pos_mid: '0,
                                   start_pos_slow: '0,
                                   direction: rssc_pkg::DIR_ENCRYPT,
                                   rotor_table: rssc_pkg::TABLE_RESET};
    logic [rssc_pkg::POS_W-1:0] rotor_fast = '0;
    logic [rssc_pkg::POS_W-1:0] rotor_mid  = '0;
    logic [rssc_pkg::POS_W-1:0] rotor_slow = '0;

    rssc_pkg::in_t  char_q[$];
    rssc_pkg::out_t cipher_q[$];

    int beats_queued = 0;
    int results_seen = 0;
    int failures = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    bit quiet_tail = 1'b0;
    int hold_token = 0;
    int hold_ack = 0;
    int hold_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [3:0] rotor_key(input logic [rssc_pkg::POS_W-1:0] pos);
        int base;
        base = int'(pos) * 4;
        if (int'(pos) >= rssc_pkg::TABLE_ENTRIES) begin
            return 4'd0;
        end
        return shadow_cfg.rotor_table[base +: 4];
    endfunction

    function automatic logic [rssc_pkg::POS_W-1:0] rotor_next(
            input logic [rssc_pkg::POS_W-1:0] pos);
        if (int'(pos) + 1 >= rssc_pkg::ROTOR_POSITIONS) begin
            return '0;
        end
        return pos + 1'b1;
    endfunction

    function automatic rssc_pkg::out_t encipher_beat(input rssc_pkg::in_t beat);
        rssc_pkg::out_t result;
        logic [7:0]     c;
        int             idx1;
        int             key;
        int             v;
        if (beat.start_message) begin
            rotor_fast = shadow_cfg.start_pos_fast;
            rotor_mid  = shadow_cfg.start_pos_mid;
            rotor_slow = shadow_cfg.start_pos_slow;
        end
        key = rotor_key(rotor_fast) + rotor_key(rotor_mid) + rotor_key(rotor_slow);
        c = beat.in_char;
        if (c >= rssc_pkg::CHAR_LOWER_A && c <= rssc_pkg::CHAR_LOWER_Z) begin
            c = c - rssc_pkg::CASE_OFFSET;
        end
        if (c >= rssc_pkg::CHAR_UPPER_A && c <= rssc_pkg::CHAR_UPPER_Z) begin
            idx1 = int'(c) - int'(rssc_pkg::CHAR_UPPER_A) + 1;
        end else if (c == rssc_pkg::CHAR_SPACE) begin
            idx1 = rssc_pkg::ALPHABET_LEN;
        end else begin
            idx1 = 0;
        end
        v = idx1 + rssc_pkg::ALPHABET_LEN - 1;
        if (shadow_cfg.direction == rssc_pkg::DIR_DECRYPT) begin
            v = (v + 2 * rssc_pkg::ALPHABET_LEN - key) % rssc_pkg::ALPHABET_LEN;
        end else begin
            v = (v + key) % rssc_pkg::ALPHABET_LEN;
        end
        result.out_char = (v == rssc_pkg::ALPHABET_LEN - 1) ? rssc_pkg::CHAR_SPACE
                                                             : rssc_pkg::CHAR_UPPER_A + 8'(v);
        result.key_used = rssc_pkg::KEY_W'(key);
        // The rotors step like an odometer after every character.
        if (int'(rotor_fast) + 1 >= rssc_pkg::ROTOR_POSITIONS) begin
            if (int'(rotor_mid) + 1 >= rssc_pkg::ROTOR_POSITIONS) begin
                rotor_slow = rotor_next(rotor_slow);
            end
            rotor_mid = rotor_next(rotor_mid);
        end
        rotor_fast = rotor_next(rotor_fast);
        return result;
    endfunction

    always @(posedge aclk) begin
        logic holding;
        holding = s_valid && !s_ready;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cipher_q.push_back(encipher_beat(s_data));
            end
            if (!holding) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (char_q.size() > 0) begin
                    s_data  <= char_q.pop_front();
                    s_valid <= 1'b1;
                    if (!quiet_tail && $urandom_range(0, 99) < tx_idle_pct) begin
                        tx_gap = $urandom_range(1, 17);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        rssc_pkg::out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (cipher_q.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result beat, actual char %h key %0d",
                             $time, m_data.out_char, m_data.key_used);
                end else begin
                    want = cipher_q.pop_front();
                    if (m_data.out_char !== want.out_char) begin
                        failures++;
                        $display("%0t: out_char mismatch, expected %h actual %h",
                                 $time, want.out_char, m_data.out_char);
                    end
                    if (m_data.key_used !== want.key_used) begin
                        failures++;
                        $display("%0t: key_used mismatch, expected %0d actual %0d",
                                 $time, want.key_used, m_data.key_used);
                    end
                end
            end
            if (hold_token != hold_ack) begin
                hold_ack  = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < rx_idle_pct) begin
                rx_gap = $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic queue_char(input logic [7:0] c, input logic start);
        rssc_pkg::in_t beat;
        beat.in_char = c;
        beat.start_message = start;
        char_q.push_back(beat);
        beats_queued++;
    endtask

    task automatic write_reg(input logic [rssc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rssc_pkg::TABLE_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        case (idx)
            rssc_pkg::CFG_START_FAST:
                shadow_cfg.start_pos_fast = data[rssc_pkg::POS_W-1:0];
            rssc_pkg::CFG_START_MID:
                shadow_cfg.start_pos_mid  = data[rssc_pkg::POS_W-1:0];
            rssc_pkg::CFG_START_SLOW:
                shadow_cfg.start_pos_slow = data[rssc_pkg::POS_W-1:0];
            rssc_pkg::CFG_DIRECTION:
                shadow_cfg.direction      = data[0];
            rssc_pkg::CFG_ROTOR_TABLE:
                shadow_cfg.rotor_table    = data;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (results_seen < beats_queued) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [rssc_pkg::TABLE_W-1:0] noisy_word(
            input logic [rssc_pkg::POS_W-1:0] low);
        logic [rssc_pkg::TABLE_W-1:0] w;
        w = {8'($urandom), $urandom};
        w[rssc_pkg::POS_W-1:0] = low;
        return w;
    endfunction

    function automatic logic [rssc_pkg::POS_W-1:0] pick_start();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return rssc_pkg::POS_W'(rssc_pkg::ROTOR_POSITIONS - 1);
            2: return rssc_pkg::POS_W'($urandom_range(rssc_pkg::ROTOR_POSITIONS, 15));
            default: return rssc_pkg::POS_W'($urandom_range(0, rssc_pkg::ROTOR_POSITIONS - 1));
        endcase
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return rssc_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25));
        end else if (r < 70) begin
            return rssc_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25));
        end else if (r < 82) begin
            return rssc_pkg::CHAR_SPACE;
        end
        return 8'($urandom);
    endfunction

    task automatic random_settings();
        int t;
        write_reg(rssc_pkg::CFG_START_FAST, noisy_word(pick_start()));
        write_reg(rssc_pkg::CFG_START_MID, noisy_word(pick_start()));
        write_reg(rssc_pkg::CFG_START_SLOW, noisy_word(pick_start()));
        write_reg(rssc_pkg::CFG_DIRECTION,
                  noisy_word(rssc_pkg::POS_W'($urandom_range(0, 15))));
        t = $urandom_range(0, 5);
        if (t == 0) begin
            write_reg(rssc_pkg::CFG_ROTOR_TABLE, '0);
        end else if (t == 1) begin
            write_reg(rssc_pkg::CFG_ROTOR_TABLE, '1);
        end else begin
            write_reg(rssc_pkg::CFG_ROTOR_TABLE, {8'($urandom), $urandom});
        end
        if ($urandom_range(0, 3) == 0) begin
            write_reg(rssc_pkg::CFG_IDX_W'($urandom_range(rssc_pkg::CFG_ROTOR_TABLE + 1, 7)),
                      {8'($urandom), $urandom});
        end
        end_writes();
    endtask

    task automatic random_messages(input int count);
        int target;
        int len;
        target = beats_queued + count;
        while (beats_queued < target) begin
            len = $urandom_range(1, 24);
            queue_char(pick_char(), 1'b1);
            for (int i = 1; i < len; i++) begin
                // A stray start flag now and then breaks the message up.
                queue_char(pick_char(), $urandom_range(0, 29) == 0);
            end
        end
    endtask

    function automatic int pick_idle();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: the alphabet edges, case folding and bytes outside it.
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        queue_char(rssc_pkg::CHAR_SPACE, 1'b1);
        queue_char(rssc_pkg::CHAR_UPPER_A, 1'b0);
        queue_char(rssc_pkg::CHAR_UPPER_Z, 1'b0);
        queue_char(rssc_pkg::CHAR_LOWER_A, 1'b0);
        queue_char(rssc_pkg::CHAR_LOWER_Z, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(8'hff, 1'b0);
        queue_char(8'h80, 1'b0);
        queue_char(rssc_pkg::CHAR_UPPER_A - 8'd1, 1'b0);
        queue_char(rssc_pkg::CHAR_UPPER_Z + 8'd1, 1'b0);
        queue_char(rssc_pkg::CHAR_LOWER_A - 8'd1, 1'b0);
        queue_char(rssc_pkg::CHAR_LOWER_Z + 8'd1, 1'b0);
        queue_char(8'h7f, 1'b0);
        wait_drained();

        // Largest key with every rotor on its last position, so all three carry.
        write_reg(rssc_pkg::CFG_START_FAST,
                  noisy_word(rssc_pkg::POS_W'(rssc_pkg::ROTOR_POSITIONS - 1)));
        write_reg(rssc_pkg::CFG_START_MID,
                  noisy_word(rssc_pkg::POS_W'(rssc_pkg::ROTOR_POSITIONS - 1)));
        write_reg(rssc_pkg::CFG_START_SLOW,
                  noisy_word(rssc_pkg::POS_W'(rssc_pkg::ROTOR_POSITIONS - 1)));
        write_reg(rssc_pkg::CFG_DIRECTION, rssc_pkg::TABLE_W'(rssc_pkg::DIR_DECRYPT));
        write_reg(rssc_pkg::CFG_ROTOR_TABLE, '1);
        end_writes();
        queue_char(rssc_pkg::CHAR_UPPER_A, 1'b1);
        queue_char(rssc_pkg::CHAR_UPPER_Z, 1'b0);
        queue_char(rssc_pkg::CHAR_SPACE, 1'b0);
        queue_char(8'hff, 1'b0);
        queue_char(rssc_pkg::CHAR_LOWER_A + 8'd12, 1'b0);
        wait_drained();

        // Start positions beyond the rotor range, a zero table and writes
        // to indexes past the register list. The first beat carries no start
        // flag, so the positions from before the writes must still hold.
        write_reg(rssc_pkg::CFG_START_FAST, noisy_word(4'd15));
        write_reg(rssc_pkg::CFG_START_MID, noisy_word(4'd10));
        write_reg(rssc_pkg::CFG_START_SLOW, noisy_word(4'd12));
        write_reg(rssc_pkg::CFG_DIRECTION, 40'hffffffffff - rssc_pkg::TABLE_W'(1));
        write_reg(rssc_pkg::CFG_ROTOR_TABLE, '0);
        write_reg(rssc_pkg::CFG_ROTOR_TABLE + 3'd1, '1);
        write_reg(rssc_pkg::CFG_ROTOR_TABLE + 3'd3, '1);
        end_writes();
        queue_char(rssc_pkg::CHAR_UPPER_A + 8'd16, 1'b0);
        queue_char(rssc_pkg::CHAR_UPPER_A + 8'd16, 1'b1);
        queue_char(rssc_pkg::CHAR_UPPER_A + 8'd1, 1'b0);
        queue_char(rssc_pkg::CHAR_LOWER_A + 8'd2, 1'b0);
        queue_char(8'h01, 1'b0);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_settings();
            tx_idle_pct = pick_idle();
            rx_idle_pct = pick_idle();
            if (p == RANDOM_PHASES - 1) begin
                quiet_tail = 1'b1;
            end
            random_messages(BEATS_PER_PHASE);
            if (p == 3 || p == 8) begin
                // Keep the sender busy while the output is held off for a long spell.
                tx_idle_pct = 0;
                hold_token++;
            end
            wait_drained();
        end

        repeat (16) @(posedge aclk);
        if (cipher_q.size() != 0) begin
            failures += cipher_q.size();
            $display("%0t: %0d expected result beats never arrived", $time, cipher_q.size());
        end
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> rotor_stepped_shift_cipher.f
rtl/rssc_pkg.sv
rtl/rssc_fifo.sv
rtl/rssc_front.sv
rtl/rssc_back.sv
rtl/rotor_stepped_shift_cipher.sv
rtl/rssc_checker.sv
bench/tb_top.sv
